// ===== rtl/tkchd_pkg.sv =====
package tkchd_pkg;

  localparam int CHORD_SLOTS = 2;
  localparam int MAX_RESULTS = 3;
  localparam int CFG_INDEX_W = 2;

  localparam logic [1:0] KIND_KEY   = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;

  localparam logic [1:0] SLOT_FREE    = 2'd0;
  localparam logic [1:0] SLOT_PENDING = 2'd1;
  localparam logic [1:0] SLOT_LIVE    = 2'd2;

  localparam logic [2:0] ACT_REPLAY_PRESS   = 3'd0;
  localparam logic [2:0] ACT_REPLAY_RELEASE = 3'd1;
  localparam logic [2:0] ACT_PASS           = 3'd2;
  localparam logic [2:0] ACT_CONSUME        = 3'd3;
  localparam logic [2:0] ACT_OPEN           = 3'd4;
  localparam logic [2:0] ACT_MODAL_KEY      = 3'd5;
  localparam logic [2:0] ACT_MODAL_ENC      = 3'd6;

  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_POS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SECOND_POS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TERM_TICKS = 2'd2;

  localparam logic [15:0] RESET_FIRST_POS  = 16'd0;
  localparam logic [15:0] RESET_SECOND_POS = 16'd1;
  localparam logic [15:0] RESET_TERM_TICKS = 16'd50;
  localparam logic [15:0] ELAPSED_MAX      = 16'hFFFF;

  typedef struct packed {
    logic [2:0] action;
    logic       slot;
  } result_t;

  typedef struct packed {
    logic [1:0]                  count;
    result_t [MAX_RESULTS-1:0]   res;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== rtl/tkchd_front.sv =====
module tkchd_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic [1:0]                        kind,
  input  logic [7:0]                        key_row,
  input  logic [7:0]                        key_col,
  input  logic                              pressed,
  input  logic                              is_encoder,
  input  logic                              cfg_write,
  input  logic [tkchd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                       cfg_data,
  output logic                              push,
  output tkchd_pkg::bundle_t                push_data
);

  logic [15:0] first_pos;
  logic [15:0] second_pos;
  logic [15:0] term_ticks;

  logic [1:0]  slot_state [tkchd_pkg::CHORD_SLOTS];
  logic        term_running;
  logic [15:0] term_elapsed;
  logic        modal_open;

  logic [1:0]  slot_state_next [tkchd_pkg::CHORD_SLOTS];
  logic        term_running_next;
  logic [15:0] term_elapsed_next;
  logic        modal_open_next;
  tkchd_pkg::bundle_t bnd;

  always_comb begin
    logic [1:0]  n;
    logic [15:0] pos;
    logic        hit0;
    logic        hit1;
    logic        ci;
    logic [15:0] el;
    n = 2'd0;
    bnd = '0;
    for (int j = 0; j < tkchd_pkg::CHORD_SLOTS; j++) begin
      slot_state_next[j] = slot_state[j];
    end
    term_running_next = term_running;
    term_elapsed_next = term_elapsed;
    modal_open_next = modal_open;
    pos = {key_row, key_col};
    hit0 = (pos == first_pos);
    hit1 = !hit0 && (pos == second_pos);
    ci = hit1;
    el = (term_elapsed == tkchd_pkg::ELAPSED_MAX) ? term_elapsed : term_elapsed + 16'd1;
    case (kind)
      tkchd_pkg::KIND_KEY: begin
        if (modal_open) begin
          if (pressed) begin
            bnd.res[0].action = is_encoder ? tkchd_pkg::ACT_MODAL_ENC : tkchd_pkg::ACT_MODAL_KEY;
          end else begin
            bnd.res[0].action = tkchd_pkg::ACT_CONSUME;
          end
          n = 2'd1;
        end else if (!hit0 && !hit1) begin
          if (pressed) begin
            for (int j = 0; j < tkchd_pkg::CHORD_SLOTS; j++) begin
              if (slot_state[j] == tkchd_pkg::SLOT_PENDING) begin
                bnd.res[n].action = tkchd_pkg::ACT_REPLAY_PRESS;
                bnd.res[n].slot = 1'(j);
                n = n + 2'd1;
                slot_state_next[j] = tkchd_pkg::SLOT_LIVE;
              end
            end
            term_running_next = 1'b0;
            term_elapsed_next = '0;
          end
          bnd.res[n].action = tkchd_pkg::ACT_PASS;
          n = n + 2'd1;
        end else if (pressed) begin
          if (slot_state[!ci] == tkchd_pkg::SLOT_PENDING) begin
            for (int j = 0; j < tkchd_pkg::CHORD_SLOTS; j++) begin
              slot_state_next[j] = tkchd_pkg::SLOT_FREE;
            end
            term_running_next = 1'b0;
            term_elapsed_next = '0;
            modal_open_next = 1'b1;
            bnd.res[0].action = tkchd_pkg::ACT_OPEN;
          end else begin
            slot_state_next[ci] = tkchd_pkg::SLOT_PENDING;
            if (!term_running) begin
              term_running_next = 1'b1;
              term_elapsed_next = '0;
            end
            bnd.res[0].action = tkchd_pkg::ACT_CONSUME;
          end
          n = 2'd1;
        end else if (slot_state[ci] == tkchd_pkg::SLOT_PENDING) begin
          slot_state_next[ci] = tkchd_pkg::SLOT_FREE;
          bnd.res[0].action = tkchd_pkg::ACT_REPLAY_PRESS;
          bnd.res[0].slot = ci;
          bnd.res[1].action = tkchd_pkg::ACT_REPLAY_RELEASE;
          bnd.res[1].slot = ci;
          n = 2'd2;
          term_running_next = 1'b0;
          term_elapsed_next = '0;
        end else begin
          slot_state_next[ci] = tkchd_pkg::SLOT_FREE;
          bnd.res[0].action = tkchd_pkg::ACT_PASS;
          n = 2'd1;
        end
      end
      tkchd_pkg::KIND_TICK: begin
        if (term_running) begin
          term_elapsed_next = el;
          if (el > term_ticks) begin
            for (int j = 0; j < tkchd_pkg::CHORD_SLOTS; j++) begin
              if (slot_state[j] == tkchd_pkg::SLOT_PENDING) begin
                bnd.res[n].action = tkchd_pkg::ACT_REPLAY_PRESS;
                bnd.res[n].slot = 1'(j);
                n = n + 2'd1;
                slot_state_next[j] = tkchd_pkg::SLOT_LIVE;
              end
            end
            term_running_next = 1'b0;
            term_elapsed_next = '0;
          end
        end
      end
      tkchd_pkg::KIND_CLOSE: begin
        if (modal_open) begin
          modal_open_next = 1'b0;
          for (int j = 0; j < tkchd_pkg::CHORD_SLOTS; j++) begin
            slot_state_next[j] = tkchd_pkg::SLOT_FREE;
          end
          term_running_next = 1'b0;
          term_elapsed_next = '0;
        end
      end
      default: begin
      end
    endcase
    bnd.count = n;
  end

  assign push = accept && (bnd.count != 2'd0);
  assign push_data = bnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_pos <= tkchd_pkg::RESET_FIRST_POS;
      second_pos <= tkchd_pkg::RESET_SECOND_POS;
      term_ticks <= tkchd_pkg::RESET_TERM_TICKS;
    end else if (cfg_write) begin
      case (cfg_index)
        tkchd_pkg::REG_FIRST_POS:  first_pos <= cfg_data;
        tkchd_pkg::REG_SECOND_POS: second_pos <= cfg_data;
        tkchd_pkg::REG_TERM_TICKS: term_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < tkchd_pkg::CHORD_SLOTS; j++) begin
        slot_state[j] <= tkchd_pkg::SLOT_FREE;
      end
      term_running <= 1'b0;
      term_elapsed <= '0;
      modal_open <= 1'b0;
    end else if (accept) begin
      for (int j = 0; j < tkchd_pkg::CHORD_SLOTS; j++) begin
        slot_state[j] <= slot_state_next[j];
      end
      term_running <= term_running_next;
      term_elapsed <= term_elapsed_next;
      modal_open <= modal_open_next;
    end
  end

`ifndef SYNTHESIS
  a_modal_clears_chord: assert property (@(posedge clk) disable iff (rst)
    modal_open |-> (!term_running && slot_state[0] == tkchd_pkg::SLOT_FREE &&
                    slot_state[1] == tkchd_pkg::SLOT_FREE))
    else $error("modal open while chord state is not clear");
`endif

endmodule

// ===== rtl/tkchd_queue.sv =====
module tkchd_queue #(
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  tkchd_pkg::bundle_t       push_data,
  input  logic                     pop,
  output tkchd_pkg::bundle_t       head,
  output tkchd_pkg::queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tkchd_pkg::bundle_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.full = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push = push && !status.full;
  assign do_pop = pop && !status.empty;
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !status.full)
    else $error("word pushed into full queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count out of range");
`endif

endmodule

// ===== rtl/tkchd_back.sv =====
module tkchd_back (
  input  logic                     clk,
  input  logic                     rst,
  input  tkchd_pkg::bundle_t       head,
  input  tkchd_pkg::queue_status_t status,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2:0]               action,
  output logic                     chord_slot,
  output logic                     last
);

  tkchd_pkg::bundle_t cur;
  logic               cur_valid;
  logic [1:0]         idx;
  logic               load;

  assign out_valid = cur_valid;
  assign action = cur.res[idx].action;
  assign chord_slot = cur.res[idx].slot;
  assign last = (idx == cur.count - 2'd1);
  assign load = !cur_valid || (out_ready && last);
  assign pop = load && !status.empty;

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx <= '0;
    end else if (load) begin
      cur_valid <= !status.empty;
      idx <= '0;
    end else if (out_ready) begin
      idx <= idx + 2'd1;
    end
  end

`ifndef SYNTHESIS
  a_word_has_results: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.count != 2'd0 && idx < cur.count))
    else $error("result index outside the current bundle");
`endif

endmodule

// ===== rtl/two_key_chord_holdback_detector_unit.sv =====
// Each result word is registered in the queue and then in the result sequencer before it appears.
// Throughput: one input word per cycle while the queue is not full; results leave one per output handshake.
// An input causes up to three results, so the output port sets the sustained rate.
// The queue between classifier and result sequencer holds QUEUE_DEPTH bundles.
// Synchronous active-high reset clears chord state and restores register defaults.
module two_key_chord_holdback_detector_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        kind,
  input  logic [7:0]                        key_row,
  input  logic [7:0]                        key_col,
  input  logic                              pressed,
  input  logic                              is_encoder,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        action,
  output logic                              chord_slot,
  output logic                              last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tkchd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                       cfg_data
);

  logic                     accept;
  logic                     push;
  logic                     pop;
  tkchd_pkg::bundle_t       push_data;
  tkchd_pkg::bundle_t       head;
  tkchd_pkg::queue_status_t status;

  assign in_ready = !status.full;
  assign accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  tkchd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .kind       (kind),
    .key_row    (key_row),
    .key_col    (key_col),
    .pressed    (pressed),
    .is_encoder (is_encoder),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_data  (push_data)
  );

  tkchd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (status)
  );

  tkchd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .status     (status),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .action     (action),
    .chord_slot (chord_slot),
    .last       (last)
  );

endmodule
